>>> hdl/dht_pkg.sv
// dht_pkg: shared widths, codes and constants of the double hashing table core
// no dependencies; imported by dht_mod and double_hash_table_core
`default_nettype none

package dht_pkg;

   // item field widths
   localparam int KEY_W      = 32;
   localparam int OP_W       = 1;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 10;
   localparam int CMP_W      = 11;

   // configuration registers
   localparam int TSIZE_W    = 11;
   localparam int SMOD_W     = 10;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MOD   = 1'b1;
   localparam logic [TSIZE_W-1:0]   TSIZE_RESET    = 11'd1024;
   localparam logic [SMOD_W-1:0]    SMOD_RESET     = 10'd1021;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
   localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   // result packing
   localparam int RSP_RAW_W  = STATUS_W + SLOT_W + CMP_W;
   localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_RAW_W;

   // digit-serial remainder unit
   localparam int DIG_W       = 4;
   localparam int KEY_DIGITS  = KEY_W / DIG_W;
   localparam int STEP_DIGITS = (SMOD_W + DIG_W - 1) / DIG_W;
   localparam int STEP_SHIFT  = KEY_W - STEP_DIGITS * DIG_W;
   localparam int DCNT_W      = $clog2(KEY_DIGITS + 1);

endpackage

`default_nettype wire

>>> hdl/dht_ram.sv
// dht_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
`default_nettype none

module dht_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/dht_mod.sv
// dht_mod: digit-serial remainder unit, DIG_W dividend bits per cycle, MSB first
// depends on dht_pkg
`default_nettype none

module dht_mod import dht_pkg::*; #(
   parameter int DW = 11
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [KEY_W-1:0]  dividend,
   input  wire logic [DCNT_W-1:0] digits,
   input  wire logic [DW-1:0]     divisor,
   output logic                   done,
   output logic      [DW-1:0]     rem
);

   logic              busy_ff, busy_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [KEY_W-1:0]  sh_ff, sh_in;
   logic [DW-1:0]     t_rem;
   logic [KEY_W-1:0]  t_sh;
   logic [DW:0]       acc;

   // one digit of restoring reduction: shift in a bit, subtract when it fits
   always_comb begin
      t_rem = rem_ff;
      t_sh  = sh_ff;
      acc   = '0;
      for (int k = 0; k < DIG_W; k++) begin
         acc = {t_rem, t_sh[KEY_W-1]};
         if (acc >= {1'b0, divisor}) begin
            acc = acc - {1'b0, divisor};
         end
         t_rem = acc[DW-1:0];
         t_sh  = {t_sh[KEY_W-2:0], 1'b0};
      end
   end

   // sequencing
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = digits;
         rem_in  = '0;
         sh_in   = dividend;
      end else if (busy_ff && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - DCNT_W'(1);
         rem_in = t_rem;
         sh_in  = t_sh;
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

   assign done = busy_ff && (cnt_ff == '0);
   assign rem  = rem_ff;

endmodule

`default_nettype wire

>>> hdl/double_hash_table_core.sv
// double_hash_table_core: open-addressing hash table with double hashing
// depends on dht_pkg, dht_mod and dht_ram
//
//   channel   dir  handshake             payload
//   req_      in   req_tvalid/tready     tdata: key[31:0]; tuser: op[0]
//   rsp_      out  rsp_tvalid/tready     tdata: status[1:0] slot[11:2] comparisons[22:12]
//   csr_      in   csr_we (no wait)      csr_index, csr_wdata
//
// one item at a time: the home slot and step remainders of the 32-bit key are computed
// together (4 bits a cycle), then the step is reduced by the table size, then slots are
// read from the table RAM, one slot read a cycle, each checked when its registered read returns.
// after reset a clearing pass empties the table; no item is taken
// during it. a result waits in the output register; the next item is taken meanwhile.
`default_nettype none

module double_hash_table_core import dht_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [KEY_W-1:0]      req_tdata,   // key
   input  wire logic [OP_W-1:0]       req_tuser,   // op
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // status, slot, comparisons, pad
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PW    = $clog2(CAPACITY);
   localparam int SW    = (PW + 1 > TSIZE_W) ? PW + 1 : TSIZE_W;
   localparam int RAM_W = KEY_W + 1;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_STEP  = 3'd3;
   localparam logic [2:0] S_PROBE = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [TSIZE_W-1:0]  tsize_ff;
   logic [SMOD_W-1:0]   smod_ff;
   logic [2:0]          state_ff, state_in;
   logic [PW-1:0]       clr_ff, clr_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [PW-1:0]       step_ff, step_in;
   logic [SW-1:0]       issue_ff, issue_in;
   logic [SW-1:0]       eval_ff, eval_in;
   logic [SW-1:0]       passed_ff, passed_in;
   logic                rv_ff, rv_in;
   logic [PW-1:0]       rpos_ff, rpos_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [CMP_W-1:0]    res_cmp_ff, res_cmp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [CMP_W-1:0]    rsp_cmp_ff, rsp_cmp_in;

   logic                accept;
   logic [SW-1:0]       ts_ext;
   logic [SW-1:0]       size_w;
   logic [SMOD_W-1:0]   rmod_w;
   logic                hmod_start;
   logic [KEY_W-1:0]    hmod_dividend;
   logic [DCNT_W-1:0]   hmod_digits;
   logic                hmod_done;
   logic [SW-1:0]       hmod_rem;
   logic                smod_done;
   logic [SMOD_W-1:0]   smod_rem;
   logic [SMOD_W-1:0]   stepval;
   logic [KEY_W-1:0]    step_div;
   logic [SW-1:0]       pos_sum;
   logic [PW-1:0]       pos_next;
   logic [SW-1:0]       eval_next;
   logic [SW-1:0]       passed_next;
   logic                ram_we;
   logic [PW-1:0]       ram_waddr;
   logic [RAM_W-1:0]    ram_wdata;
   logic                ram_re;
   logic [RAM_W-1:0]    ram_rdata;
   logic                rd_valid;
   logic [KEY_W-1:0]    rd_key;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff <= TSIZE_RESET;
         smod_ff  <= SMOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TABLE_SIZE: tsize_ff <= csr_wdata[TSIZE_W-1:0];
            CSR_STEP_MOD:   smod_ff  <= csr_wdata[SMOD_W-1:0];
            default: ;
         endcase
      end
   end

   // effective table size and step modulus
   assign ts_ext = SW'(tsize_ff);
   always_comb begin
      if (ts_ext < SW'(2)) begin
         size_w = SW'(2);
      end else if (ts_ext > SW'(CAPACITY)) begin
         size_w = SW'(CAPACITY);
      end else begin
         size_w = ts_ext;
      end
   end
   assign rmod_w = (smod_ff == '0) ? SMOD_W'(1) : smod_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // remainder units: home slot and step hash, then the step reduced by the size
   assign stepval       = rmod_w - smod_rem;
   assign step_div      = KEY_W'(stepval) << STEP_SHIFT;
   assign hmod_start    = accept || ((state_ff == S_HASH) && hmod_done);
   assign hmod_dividend = accept ? req_tdata : step_div;
   assign hmod_digits   = accept ? DCNT_W'(KEY_DIGITS) : DCNT_W'(STEP_DIGITS);

   dht_mod #(.DW(SW)) u_home_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (hmod_start),
      .dividend (hmod_dividend),
      .digits   (hmod_digits),
      .divisor  (size_w),
      .done     (hmod_done),
      .rem      (hmod_rem)
   );

   dht_mod #(.DW(SMOD_W)) u_step_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (req_tdata),
      .digits   (DCNT_W'(KEY_DIGITS)),
      .divisor  (rmod_w),
      .done     (smod_done),
      .rem      (smod_rem)
   );

   // table memory: valid bit over the key
   dht_ram #(.WIDTH(RAM_W), .DEPTH(CAPACITY)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   assign rd_valid = ram_rdata[KEY_W];
   assign rd_key   = ram_rdata[KEY_W-1:0];

   // next probe position
   assign pos_sum     = SW'(pos_ff) + SW'(step_ff);
   assign pos_next    = (pos_sum >= size_w) ? PW'(pos_sum - size_w) : PW'(pos_sum);
   assign eval_next   = eval_ff + SW'(1);
   assign passed_next = passed_ff + SW'(1);

   // control sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      issue_in      = issue_ff;
      eval_in       = eval_ff;
      passed_in     = passed_ff;
      rv_in         = 1'b0;
      rpos_in       = rpos_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_cmp_in    = res_cmp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_cmp_in    = rsp_cmp_ff;
      ram_we        = 1'b0;
      ram_waddr     = rpos_ff;
      ram_wdata     = {1'b1, key_ff};
      ram_re        = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + PW'(1);
            if (clr_ff == PW'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in    = req_tuser;
               key_in   = req_tdata;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hmod_done) begin
               pos_in   = PW'(hmod_rem);
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (hmod_done) begin
               step_in   = PW'(hmod_rem);
               issue_in  = '0;
               eval_in   = '0;
               passed_in = '0;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            // issue one read a cycle until the probe cap
            if (issue_ff < size_w) begin
               ram_re   = 1'b1;
               pos_in   = pos_next;
               issue_in = issue_ff + SW'(1);
               rv_in    = 1'b1;
               rpos_in  = pos_ff;
            end
            // check the slot read last cycle
            if (rv_ff) begin
               eval_in = eval_next;
               if (op_ff == OP_INSERT) begin
                  if (!rd_valid) begin
                     ram_we        = 1'b1;
                     res_status_in = ST_INSERTED;
                     res_slot_in   = SLOT_W'(rpos_ff);
                     res_cmp_in    = '0;
                     state_in      = S_EMIT;
                  end else if (eval_next == size_w) begin
                     res_status_in = ST_FULL;
                     res_slot_in   = '0;
                     res_cmp_in    = '0;
                     state_in      = S_EMIT;
                  end
               end else begin
                  if (!rd_valid) begin
                     res_status_in = ST_NOT_FOUND;
                     res_slot_in   = '0;
                     res_cmp_in    = CMP_W'(passed_ff);
                     state_in      = S_EMIT;
                  end else if (rd_key == key_ff) begin
                     res_status_in = ST_FOUND;
                     res_slot_in   = SLOT_W'(rpos_ff);
                     res_cmp_in    = CMP_W'(passed_ff);
                     state_in      = S_EMIT;
                  end else begin
                     passed_in = passed_next;
                     if (eval_next == size_w) begin
                        res_status_in = ST_NOT_FOUND;
                        res_slot_in   = '0;
                        res_cmp_in    = CMP_W'(passed_next);
                        state_in      = S_EMIT;
                     end
                  end
               end
            end
         end
         S_EMIT: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_cmp_in    = res_cmp_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      issue_ff      <= issue_in;
      eval_ff       <= eval_in;
      passed_ff     <= passed_in;
      rpos_ff       <= rpos_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_cmp_ff    <= res_cmp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_cmp_ff    <= rsp_cmp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_cmp_ff, rsp_slot_ff, rsp_status_ff};

   // probe position stays inside the table in use
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (SW'(pos_ff) < size_w))
      else $error("probe position beyond table size");

   // both key remainders finish together
   a_mod_lockstep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HASH) |-> (hmod_done == smod_done))
      else $error("remainder units out of step");

   // a table write during probing ends the item as an insert
   a_write_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_PROBE) && ram_we) |=>
         ((state_ff == S_EMIT) && (res_status_ff == ST_INSERTED)))
      else $error("table write without insert result");

   // an accepted item starts hashing
   a_accept_hash: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_HASH))
      else $error("accepted item not hashed");

endmodule

`default_nettype wire
